// ===== hw/rtl/hfbt_pkg.sv =====
package hfbt_pkg;

  localparam int PATTERN_LEN = 8;
  localparam int CODE_BITS = 12;
  localparam int MAX_RUN = (PATTERN_LEN > CODE_BITS) ? PATTERN_LEN : CODE_BITS;
  localparam int CNT_W = $clog2(MAX_RUN);

  typedef logic [1:0] phase_t;
  localparam phase_t PH_PRE = 2'd0;
  localparam phase_t PH_CODE = 2'd1;
  localparam phase_t PH_POST = 2'd2;

  typedef logic [CODE_BITS-1:0] code_t;

  typedef struct packed {
    logic has_char;
    logic frame_start;
    logic frame_end;
  } flags_t;

endpackage

// ===== hw/rtl/hfbt_encode.sv =====
module hfbt_encode (
  input  logic [7:0]     char_byte,
  output hfbt_pkg::code_t code_word
);
  import hfbt_pkg::*;

  logic [CODE_BITS-1:0] pos;

  // Codeword position 1 lands in the MSB so the serializer shifts out MSB first.
  always_comb begin
    pos = '0;
    pos[2]  = char_byte[7];
    pos[4]  = char_byte[6];
    pos[5]  = char_byte[5];
    pos[6]  = char_byte[4];
    pos[8]  = char_byte[3];
    pos[9]  = char_byte[2];
    pos[10] = char_byte[1];
    pos[11] = char_byte[0];
    pos[0]  = pos[2] ^ pos[4] ^ pos[6] ^ pos[8] ^ pos[10];
    pos[1]  = pos[2] ^ pos[5] ^ pos[6] ^ pos[9] ^ pos[10];
    pos[3]  = pos[4] ^ pos[5] ^ pos[6] ^ pos[11];
    pos[7]  = pos[8] ^ pos[9] ^ pos[10] ^ pos[11];
    for (int k = 0; k < CODE_BITS; k++) begin
      code_word[CODE_BITS-1-k] = pos[k];
    end
  end

endmodule

// ===== hw/rtl/hfbt_seq.sv =====
module hfbt_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hfbt_pkg::flags_t load_flags,
  input  hfbt_pkg::code_t  load_code,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_line_bit,
  output hfbt_pkg::phase_t out_bit_phase,
  output logic             out_run_last
);
  import hfbt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PRE  = 4'b0010,
    S_CODE = 4'b0100,
    S_POST = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  flags_t           flags_r, flags_nxt;
  code_t            shift_r, shift_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             vld_r, vld_nxt;
  logic             bit_r, bit_nxt;
  phase_t           phase_r, phase_nxt;
  logic             last_r, last_nxt;
  logic             emit;
  logic             seg_end;

  assign busy = (state_r != S_IDLE);
  assign emit = busy && (!vld_r || !out_stall);

  always_comb begin
    case (state_r)
      S_CODE:  seg_end = (cnt_r == CNT_W'(CODE_BITS - 1));
      S_PRE,
      S_POST:  seg_end = (cnt_r == CNT_W'(PATTERN_LEN - 1));
      default: seg_end = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    flags_nxt = flags_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    vld_nxt   = vld_r && out_stall;
    bit_nxt   = bit_r;
    phase_nxt = phase_r;
    last_nxt  = last_r;

    if (load) begin
      flags_nxt = load_flags;
      shift_nxt = load_code;
      cnt_nxt   = '0;
      if (load_flags.frame_start) begin
        state_nxt = S_PRE;
      end else if (load_flags.has_char) begin
        state_nxt = S_CODE;
      end else if (load_flags.frame_end) begin
        state_nxt = S_POST;
      end else begin
        state_nxt = S_IDLE;
      end
    end else if (emit) begin
      vld_nxt = 1'b1;
      cnt_nxt = seg_end ? '0 : cnt_r + 1'b1;
      case (state_r)
        S_PRE: begin
          bit_nxt   = cnt_r[0];
          phase_nxt = PH_PRE;
          last_nxt  = seg_end && !flags_r.has_char && !flags_r.frame_end;
          if (seg_end) begin
            if (flags_r.has_char) begin
              state_nxt = S_CODE;
            end else if (flags_r.frame_end) begin
              state_nxt = S_POST;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
        S_CODE: begin
          bit_nxt   = shift_r[CODE_BITS-1];
          shift_nxt = {shift_r[CODE_BITS-2:0], 1'b0};
          phase_nxt = PH_CODE;
          last_nxt  = seg_end && !flags_r.frame_end;
          if (seg_end) begin
            state_nxt = flags_r.frame_end ? S_POST : S_IDLE;
          end
        end
        S_POST: begin
          bit_nxt   = cnt_r[0];
          phase_nxt = PH_POST;
          last_nxt  = seg_end;
          if (seg_end) begin
            state_nxt = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
    shift_r <= shift_nxt;
    bit_r   <= bit_nxt;
    phase_r <= phase_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = vld_r;
  assign out_line_bit  = bit_r;
  assign out_bit_phase = phase_r;
  assign out_run_last  = last_r;

endmodule

// ===== hw/rtl/hamming_framed_bit_transmitter_unit.sv =====
// Channel | Direction | Fields
// in_     | input     | char_byte[7:0], has_char, frame_start, frame_end
// out_    | output    | line_bit, bit_phase[1:0], run_last
//
// Each item is accepted and then sent one bit per cycle, while the output is not stalled, by a bit counter:
// 8 bits per preamble or postamble, 12 per codeword, up to 28 bits per item.
// An item with no flags set is accepted and yields nothing.
// The input is stalled while an item is being sent; a stalled output bit holds.
// Synchronous reset clears the sequencer and the output valid.
module hamming_framed_bit_transmitter_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char_byte,
  input  logic             in_has_char,
  input  logic             in_frame_start,
  input  logic             in_frame_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_line_bit,
  output hfbt_pkg::phase_t out_bit_phase,
  output logic             out_run_last
);
  import hfbt_pkg::*;

  code_t  code_word;
  flags_t in_flags;
  logic   busy;
  logic   load;

  assign in_flags.has_char    = in_has_char;
  assign in_flags.frame_start = in_frame_start;
  assign in_flags.frame_end   = in_frame_end;
  assign in_stall = busy;
  assign load     = in_valid && !busy;

  hfbt_encode u_encode (
    .char_byte (in_char_byte),
    .code_word (code_word)
  );

  hfbt_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .load_flags    (in_flags),
    .load_code     (code_word),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line_bit  (out_line_bit),
    .out_bit_phase (out_bit_phase),
    .out_run_last  (out_run_last)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hfbt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 88;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic   line_bit;
    phase_t phase;
    logic   run_last;
  } line_beat_t;

  class line_bit_predictor;
    line_beat_t pending_bits[$];
    int errors;
    int checked;
    int run_total;
    int run_count;

    function new();
      errors = 0;
      checked = 0;
    endfunction

    function bit [12:1] hamming_word(bit [7:0] d);
      bit [12:1] cw;
      cw = '0;
      cw[3] = d[7];
      cw[5] = d[6];
      cw[6] = d[5];
      cw[7] = d[4];
      cw[9] = d[3];
      cw[10] = d[2];
      cw[11] = d[1];
      cw[12] = d[0];
      cw[1] = cw[3] ^ cw[5] ^ cw[7] ^ cw[9] ^ cw[11];
      cw[2] = cw[3] ^ cw[6] ^ cw[7] ^ cw[10] ^ cw[11];
      cw[4] = cw[5] ^ cw[6] ^ cw[7] ^ cw[12];
      cw[8] = cw[9] ^ cw[10] ^ cw[11] ^ cw[12];
      return cw;
    endfunction

    function void queue_bit(bit v, phase_t ph);
      line_beat_t b;
      run_count++;
      b.line_bit = v;
      b.phase = ph;
      b.run_last = (run_count == run_total);
      pending_bits.push_back(b);
    endfunction

    function void note_item(bit [7:0] ch, bit has, bit st, bit en);
      bit [12:1] cw;
      run_total = (st ? PATTERN_LEN : 0) + (has ? CODE_BITS : 0) + (en ? PATTERN_LEN : 0);
      run_count = 0;
      cw = hamming_word(ch);
      if (st) begin
        for (int i = 0; i < PATTERN_LEN; i++) queue_bit(i[0], PH_PRE);
      end
      if (has) begin
        for (int p = 1; p <= CODE_BITS; p++) queue_bit(cw[p], PH_CODE);
      end
      if (en) begin
        for (int i = 0; i < PATTERN_LEN; i++) queue_bit(i[0], PH_POST);
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 20) $display("line bit %0d: %s", checked, what);
    endtask

    task check_bit(logic v, logic [1:0] ph, logic last);
      line_beat_t exp_bit;
      if (pending_bits.size() == 0) begin
        report($sformatf("unexpected bit %b phase %0d last %b", v, ph, last));
      end else begin
        exp_bit = pending_bits.pop_front();
        if (v !== exp_bit.line_bit)
          report($sformatf("line_bit %b, expected %b", v, exp_bit.line_bit));
        if (ph !== exp_bit.phase)
          report($sformatf("bit_phase %0d, expected %0d", ph, exp_bit.phase));
        if (last !== exp_bit.run_last)
          report($sformatf("run_last %b, expected %b", last, exp_bit.run_last));
      end
      checked++;
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_byte = '0;
  logic       in_has_char = 1'b0;
  logic       in_frame_start = 1'b0;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_line_bit;
  phase_t     out_bit_phase;
  logic       out_run_last;

  logic steady = 1'b0;
  logic hold_rx = 1'b0;
  logic pressure_go = 1'b0;
  int   cycle_count = 0;

  line_bit_predictor tracker = new();

  hamming_framed_bit_transmitter_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_byte(in_char_byte),
    .in_has_char(in_has_char),
    .in_frame_start(in_frame_start),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_line_bit(out_line_bit),
    .out_bit_phase(out_bit_phase),
    .out_run_last(out_run_last)
  );

  always #10 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic offer(bit [7:0] ch, bit has, bit st, bit en);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= ch;
    in_has_char <= has;
    in_frame_start <= st;
    in_frame_end <= en;
    do @(posedge clk); while (in_stall);
    tracker.note_item(ch, has, st, en);
  endtask

  task automatic send_message(int len);
    if (len == 0) begin
      offer(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
    end else begin
      for (int j = 0; j < len; j++) begin
        offer(8'($urandom_range(0, 255)), 1'b1, j == 0, j == len - 1);
      end
    end
  endtask

  // Receiver: checks each accepted beat and decides the stall for the next cycle.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        tracker.check_bit(out_line_bit, out_bit_phase, out_run_last);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!steady && $urandom_range(0, 99) < 15) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_rx;
      end
    end
  end

  // Long receiver hold-off so that the block backs up into its input.
  initial begin
    do @(posedge clk); while (!pressure_go);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int busy_items;
    int r;
    bit [7:0] ch;
    bit has;
    bit st;
    bit en;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(8'hFF, 1'b0, 1'b0, 1'b0);
    offer(8'h00, 1'b1, 1'b0, 1'b0);
    offer(8'hFF, 1'b1, 1'b0, 1'b0);
    offer(8'h01, 1'b1, 1'b0, 1'b0);
    offer(8'h80, 1'b1, 1'b0, 1'b0);
    offer(8'hAA, 1'b1, 1'b0, 1'b0);
    offer(8'h55, 1'b1, 1'b0, 1'b0);
    offer(8'h3C, 1'b0, 1'b1, 1'b0);
    offer(8'hC3, 1'b0, 1'b0, 1'b1);
    offer(8'h00, 1'b0, 1'b1, 1'b1);
    offer(8'hFF, 1'b0, 1'b1, 1'b1);
    offer(8'h00, 1'b0, 1'b0, 1'b0);
    offer(8'h5A, 1'b1, 1'b1, 1'b0);
    offer(8'hA5, 1'b1, 1'b0, 1'b1);
    offer(8'hC3, 1'b1, 1'b1, 1'b1);
    offer(8'h48, 1'b1, 1'b1, 1'b0);
    offer(8'h69, 1'b1, 1'b0, 1'b0);
    offer(8'h21, 1'b1, 1'b0, 1'b1);
    offer(8'h7E, 1'b0, 1'b0, 1'b0);
    offer(8'h81, 1'b0, 1'b0, 1'b0);

    pressure_go <= 1'b1;
    busy_items = 0;
    while (busy_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        steady <= ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 5);
        send_message(r);
        busy_items += (r == 0) ? 1 : r;
      end else begin
        ch = 8'($urandom_range(0, 255));
        has = 1'($urandom_range(0, 1));
        st = 1'($urandom_range(0, 1));
        en = 1'($urandom_range(0, 1));
        offer(ch, has, st, en);
        if (has || st || en) busy_items++;
      end
    end
    in_valid <= 1'b0;
    steady <= 1'b0;

    while (tracker.pending_bits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_bits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
